@@ rtl/bvst_pkg.sv @@
// Shared constants, codes and helper functions of the bond vector set table.
`default_nettype none

package bvst_pkg;

  localparam int COORD_BITS = 4;
  localparam int ID_COUNT   = 256;

  localparam int COORD_W  = 8;
  localparam int ID_W     = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  localparam int VEC_AW    = 3 * COORD_BITS;
  localparam int VEC_DEPTH = 1 << VEC_AW;
  localparam int ID_AW     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int ID_DEPTH  = 1 << ID_AW;
  localparam int CLR_W     = (VEC_AW > ID_AW) ? VEC_AW : ID_AW;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DUP   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_CHECK = 1'b1
  } func_t;

  // A coordinate fits when its bits above the signed field are a copy of the sign bit.
  function automatic logic coord_in_range(input logic signed [COORD_W-1:0] c);
    logic [COORD_W-COORD_BITS:0] hi;
    hi = c[COORD_W-1:COORD_BITS-1];
    return (hi == '0) || (hi == '1);
  endfunction

  function automatic logic [VEC_AW-1:0] vec_addr(input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y,
                                                 input logic signed [COORD_W-1:0] z);
    return {x[COORD_BITS-1:0], y[COORD_BITS-1:0], z[COORD_BITS-1:0]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/bvst_ifs.sv @@
// Request and result channel interfaces of the bond vector set table.
`default_nettype none

interface bvst_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       func;
  logic signed [bvst_pkg::COORD_W-1:0]        coord_x;
  logic signed [bvst_pkg::COORD_W-1:0]        coord_y;
  logic signed [bvst_pkg::COORD_W-1:0]        coord_z;
  logic        [bvst_pkg::ID_W-1:0]           bond_id;

  modport source (output valid, func, coord_x, coord_y, coord_z, bond_id, input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, bond_id, output ready);
endinterface

interface bvst_out_if;
  logic                                valid;
  logic                                ready;
  logic                                allowed;
  logic [bvst_pkg::STATUS_W-1:0]       status;
  logic [bvst_pkg::COUNT_W-1:0]        bond_count;

  modport source (output valid, allowed, status, bond_count, input ready);
  modport sink   (input valid, allowed, status, bond_count, output ready);
endinterface

`default_nettype wire

@@ rtl/bond_vector_set_table.sv @@
// Bond vector set table: vector bitmap and identifier bitmap held in synchronous memories.
// An accepted request waits in the request stage for its bitmap read data; its result is
// then loaded into the result register once that register is free or being taken.
// Throughput: one request per cycle while results are taken; a read of a bitmap entry
// written by the request just ahead is forwarded from that write, so no bubble is needed.
// Reset: after rst_n is released a clearing pass writes zero to every bitmap
// entry, one per cycle, for 2^max(3*COORD_BITS, log2 ID_COUNT) = 4096 cycles;
// requests are held off until it finishes and the entry count starts at zero.
`default_nettype none

module bond_vector_set_table (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bvst_in_if.sink     in_ch,
  bvst_out_if.source  out_ch
);

  // Bitmap memories
  logic vec_mem [bvst_pkg::VEC_DEPTH];
  logic id_mem  [bvst_pkg::ID_DEPTH];

  logic                              clr_active_r;
  logic [bvst_pkg::CLR_W-1:0]        clr_cnt_r;

  // Request stage, waiting for its memory read data
  logic                                 s1_valid_r;
  logic                                 s1_func_r;
  logic signed [bvst_pkg::COORD_W-1:0]  s1_x_r;
  logic signed [bvst_pkg::COORD_W-1:0]  s1_y_r;
  logic signed [bvst_pkg::COORD_W-1:0]  s1_z_r;
  logic [bvst_pkg::ID_W-1:0]            s1_id_r;
  logic                                 vec_rd_r;
  logic                                 id_rd_r;
  logic                                 vec_fwd_r;
  logic                                 id_fwd_r;

  logic [bvst_pkg::COUNT_W-1:0]         cnt_r;
  logic [bvst_pkg::COUNT_W-1:0]         cnt_nxt;

  // Result register
  logic                                 out_valid_r;
  logic                                 out_allowed_r;
  bvst_pkg::status_t                    out_status_r;
  logic [bvst_pkg::COUNT_W-1:0]         out_count_r;

  logic                                 in_accept;
  logic                                 out_free;
  logic                                 s1_adv;
  logic [bvst_pkg::VEC_AW-1:0]          in_addr;
  logic [bvst_pkg::ID_AW-1:0]           in_id_idx;
  logic [bvst_pkg::VEC_AW-1:0]          s1_addr;
  logic [bvst_pkg::ID_AW-1:0]           s1_id_idx;
  logic                                 s1_in_range;
  logic                                 s1_id_ok;
  logic                                 vec_present;
  logic                                 id_taken;
  logic                                 res_allowed;
  bvst_pkg::status_t                    res_status;
  logic                                 add_ok;
  logic                                 s1_wr;
  logic                                 vec_fwd_nxt;
  logic                                 id_fwd_nxt;

  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !clr_active_r && (!s1_valid_r || out_free);

  assign in_addr   = bvst_pkg::vec_addr(in_ch.coord_x, in_ch.coord_y, in_ch.coord_z);
  assign in_id_idx = in_ch.bond_id[bvst_pkg::ID_AW-1:0];
  assign s1_addr   = bvst_pkg::vec_addr(s1_x_r, s1_y_r, s1_z_r);
  assign s1_id_idx = s1_id_r[bvst_pkg::ID_AW-1:0];

  assign s1_in_range = bvst_pkg::coord_in_range(s1_x_r) && bvst_pkg::coord_in_range(s1_y_r)
                       && bvst_pkg::coord_in_range(s1_z_r);
  assign s1_id_ok    = {1'b0, s1_id_r} < (bvst_pkg::ID_W + 1)'(bvst_pkg::ID_COUNT);

  // Only ever set bits after the clearing pass, so forwarding is a plain OR.
  assign vec_present = s1_in_range && (vec_rd_r || vec_fwd_r);
  assign id_taken    = s1_id_ok && (id_rd_r || id_fwd_r);

  always_comb begin
    res_allowed = 1'b0;
    res_status  = bvst_pkg::STATUS_OK;
    add_ok      = 1'b0;
    if (s1_func_r == bvst_pkg::FUNC_CHECK) begin
      if (!s1_in_range) begin
        res_status = bvst_pkg::STATUS_RANGE;
      end else begin
        res_allowed = vec_present;
      end
    end else if (id_taken || vec_present) begin
      res_status = bvst_pkg::STATUS_DUP;
    end else if (!s1_in_range || !s1_id_ok) begin
      res_status = bvst_pkg::STATUS_RANGE;
    end else begin
      add_ok      = 1'b1;
      res_allowed = 1'b1;
    end
  end

  assign s1_wr       = s1_adv && add_ok;
  assign cnt_nxt     = s1_wr ? cnt_r + 1'b1 : cnt_r;
  assign vec_fwd_nxt = s1_wr && (in_addr == s1_addr);
  assign id_fwd_nxt  = s1_wr && (in_id_idx == s1_id_idx);

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      vec_mem[clr_cnt_r[bvst_pkg::VEC_AW-1:0]] <= 1'b0;
    end else if (s1_wr) begin
      vec_mem[s1_addr] <= 1'b1;
    end
    if (in_accept) begin
      vec_rd_r <= vec_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      id_mem[clr_cnt_r[bvst_pkg::ID_AW-1:0]] <= 1'b0;
    end else if (s1_wr) begin
      id_mem[s1_id_idx] <= 1'b1;
    end
    if (in_accept) begin
      id_rd_r <= id_mem[in_id_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= in_ch.func;
      s1_x_r    <= in_ch.coord_x;
      s1_y_r    <= in_ch.coord_y;
      s1_z_r    <= in_ch.coord_z;
      s1_id_r   <= in_ch.bond_id;
      vec_fwd_r <= vec_fwd_nxt;
      id_fwd_r  <= id_fwd_nxt;
    end
    if (s1_adv) begin
      out_allowed_r <= res_allowed;
      out_status_r  <= res_status;
      out_count_r   <= cnt_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.allowed    = out_allowed_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.bond_count = out_count_r;

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr |-> !clr_active_r)
    else $error("bitmap update collided with the clearing pass");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r)
    else $error("request in flight during the clearing pass");

  a_count_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_wr |=> cnt_r == $past(cnt_r))
    else $error("entry count changed without an accepted add");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r <= bvst_pkg::COUNT_W'(bvst_pkg::ID_COUNT))
    else $error("entry count passed the number of identifiers");

  a_allowed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_allowed_r) |-> out_status_r == bvst_pkg::STATUS_OK)
    else $error("allowed result carries a failure status");

endmodule

`default_nettype wire
